FILE: hdl/blpm_pkg.sv
// ----------------------------------------------------------------------------
// blpm_pkg
// Shared types and constants for the binary trie longest prefix match block.
// ----------------------------------------------------------------------------
`default_nettype none

package blpm_pkg;

  localparam int ADDR_W = 32;
  localparam int HOP_W  = 32;
  localparam int PORT_W = 4;
  localparam int LEN_W  = 6;

  // operation codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // status codes
  localparam logic ST_DONE = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_ALLOC,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  prefix_length;
    logic [HOP_W-1:0]  route_hop;
    logic [PORT_W-1:0] route_port;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [HOP_W-1:0]  fwd_hop;
    logic [PORT_W-1:0] port;
    logic              status;
  } rsp_t;

  // walk step flags
  typedef struct packed {
    logic more;      // level below the walk limit
    logic has_link;  // selected child exists
  } step_t;

endpackage

`default_nettype wire

FILE: hdl/blpm_req_if.sv
// ----------------------------------------------------------------------------
// blpm_req_if
// Request channel: operation, address, prefix length and route data.
// ----------------------------------------------------------------------------
`default_nettype none

interface blpm_req_if;

  logic            valid;
  logic            ready;
  blpm_pkg::req_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

FILE: hdl/blpm_rsp_if.sv
// ----------------------------------------------------------------------------
// blpm_rsp_if
// Response channel: match result and insert status.
// ----------------------------------------------------------------------------
`default_nettype none

interface blpm_rsp_if;

  logic            valid;
  logic            ready;
  blpm_pkg::rsp_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

FILE: hdl/binary_trie_longest_prefix_match.sv
// ----------------------------------------------------------------------------
// binary_trie_longest_prefix_match
// Operation: a lookup walks the trie level by level from the root along the
//   address bits and reports the longest matching route; an insert walks the
//   existing levels, links a new node per missing level and writes the route.
// Throughput: one request at a time; a new request is taken only when idle.
// Reset: root cleared and node count zero at once; no clearing pass needed.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_trie_longest_prefix_match #(
  parameter int MAX_NODES    = 4096,
  parameter int ADDRESS_BITS = 32,
  parameter int NUM_PORTS    = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  blpm_req_if.sink   req_i,
  blpm_rsp_if.source rsp_o
);

  localparam int LW     = $clog2(MAX_NODES + 1);
  localparam int IW     = $clog2(MAX_NODES);
  localparam int LVW    = $clog2(ADDRESS_BITS + 1);
  localparam int AW     = ADDRESS_BITS;
  localparam int HW     = blpm_pkg::HOP_W;
  localparam int PW     = blpm_pkg::PORT_W;
  localparam int NODE_W = 2 * LW + HW + PW + 1;

  typedef struct packed {
    logic [LW-1:0] child1;
    logic [LW-1:0] child0;
    logic [HW-1:0] hop;
    logic [PW-1:0] port;
    logic          route;
  } node_t;

  blpm_pkg::state_e state_q, state_d;
  node_t            root_q, root_d;
  node_t            cur_q, cur_d;
  node_t            cur;
  logic             cur_mem_q, cur_mem_d;
  logic             cur_root_q, cur_root_d;
  logic [IW-1:0]    cur_idx_q, cur_idx_d;
  logic [LW-1:0]    nodes_used_q, nodes_used_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic [LVW-1:0]   len_q, len_d;
  logic [LVW-1:0]   level_q, level_d;
  logic             op_q, op_d;
  logic [HW-1:0]    hop_q, hop_d;
  logic [PW-1:0]    port_q, port_d;
  logic             found_q, found_d;
  logic [HW-1:0]    best_hop_q, best_hop_d;
  logic [PW-1:0]    best_port_q, best_port_d;
  logic             status_q, status_d;
  logic             rsp_valid_q, rsp_valid_d;
  blpm_pkg::rsp_t   rsp_q, rsp_d;

  logic [LVW-1:0]    limit;
  logic [LW:0]       need;
  blpm_pkg::step_t   step;
  logic [LW-1:0]     link;
  logic [NODE_W-1:0] linked;
  logic [NODE_W-1:0] routed;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [NODE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IW-1:0]     ram_raddr;
  logic [NODE_W-1:0] ram_rdata;

  blpm_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // current node comes straight from the ram right after a read
  assign cur   = cur_mem_q ? node_t'(ram_rdata) : cur_q;
  assign limit = (op_q == blpm_pkg::OP_INSERT) ? len_q : LVW'(AW);
  assign need  = {1'b0, nodes_used_q} + (LW + 1)'(limit - level_q);

  blpm_step #(
    .MAX_NODES    (MAX_NODES),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_step (
    .node_i     (cur),
    .bit_i      (addr_q[AW-1]),
    .level_i    (level_q),
    .limit_i    (limit),
    .new_link_i (nodes_used_q + LW'(1)),
    .hop_i      (hop_q),
    .port_i     (port_q),
    .step_o     (step),
    .link_o     (link),
    .linked_o   (linked),
    .routed_o   (routed)
  );

  assign req_i.ready   = (state_q == blpm_pkg::S_IDLE);
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  always_comb begin
    state_d      = state_q;
    root_d       = root_q;
    cur_d        = cur_q;
    cur_mem_d    = cur_mem_q;
    cur_root_d   = cur_root_q;
    cur_idx_d    = cur_idx_q;
    nodes_used_d = nodes_used_q;
    addr_d       = addr_q;
    len_d        = len_q;
    level_d      = level_q;
    op_d         = op_q;
    hop_d        = hop_q;
    port_d       = port_q;
    found_d      = found_q;
    best_hop_d   = best_hop_q;
    best_port_d  = best_port_q;
    status_d     = status_q;
    rsp_valid_d  = rsp_valid_q;
    rsp_d        = rsp_q;
    ram_we       = 1'b0;
    ram_waddr    = cur_idx_q;
    ram_wdata    = linked;
    ram_re       = 1'b0;
    ram_raddr    = IW'(link - LW'(1));

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      blpm_pkg::S_IDLE: begin
        if (req_i.valid) begin
          op_d   = req_i.payload.operation;
          addr_d = req_i.payload.address[AW-1:0];
          hop_d  = req_i.payload.route_hop;
          if (req_i.payload.prefix_length > blpm_pkg::LEN_W'(AW)) begin
            len_d = LVW'(AW);
          end else begin
            len_d = LVW'(req_i.payload.prefix_length);
          end
          if (32'(req_i.payload.route_port) >= 32'(NUM_PORTS)) begin
            port_d = PW'(NUM_PORTS - 1);
          end else begin
            port_d = req_i.payload.route_port;
          end
          cur_d       = root_q;
          cur_mem_d   = 1'b0;
          cur_root_d  = 1'b1;
          level_d     = '0;
          found_d     = root_q.route;
          best_hop_d  = root_q.hop;
          best_port_d = root_q.port;
          state_d     = blpm_pkg::S_WALK;
        end
      end

      blpm_pkg::S_WALK: begin
        if (op_q == blpm_pkg::OP_LOOKUP && cur_mem_q && cur.route) begin
          found_d     = 1'b1;
          best_hop_d  = cur.hop;
          best_port_d = cur.port;
        end
        cur_d     = cur;
        cur_mem_d = 1'b0;
        if (step.more && step.has_link) begin
          ram_re     = 1'b1;
          cur_mem_d  = 1'b1;
          cur_idx_d  = IW'(link - LW'(1));
          cur_root_d = 1'b0;
          level_d    = level_q + LVW'(1);
          addr_d     = {addr_q[AW-2:0], 1'b0};
        end else if (op_q == blpm_pkg::OP_LOOKUP) begin
          status_d = blpm_pkg::ST_DONE;
          state_d  = blpm_pkg::S_FINISH;
        end else if (need > (LW + 1)'(MAX_NODES)) begin
          // not enough free nodes: leave the table untouched
          status_d = blpm_pkg::ST_FULL;
          state_d  = blpm_pkg::S_FINISH;
        end else begin
          state_d = blpm_pkg::S_ALLOC;
        end
      end

      blpm_pkg::S_ALLOC: begin
        if (step.more) begin
          // link a fresh node below the current one, new node held in cur_q
          if (cur_root_q) begin
            root_d = node_t'(linked);
          end else begin
            ram_we = 1'b1;
          end
          cur_d        = '0;
          cur_idx_d    = IW'(nodes_used_q);
          cur_root_d   = 1'b0;
          nodes_used_d = nodes_used_q + LW'(1);
          level_d      = level_q + LVW'(1);
          addr_d       = {addr_q[AW-2:0], 1'b0};
        end else begin
          ram_wdata = routed;
          if (cur_root_q) begin
            root_d = node_t'(routed);
          end else begin
            ram_we = 1'b1;
          end
          status_d = blpm_pkg::ST_DONE;
          state_d  = blpm_pkg::S_FINISH;
        end
      end

      blpm_pkg::S_FINISH: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          if (op_q == blpm_pkg::OP_LOOKUP) begin
            rsp_d.found   = found_q;
            rsp_d.fwd_hop = found_q ? best_hop_q : '0;
            rsp_d.port    = found_q ? best_port_q : '0;
          end else begin
            rsp_d.found   = 1'b0;
            rsp_d.fwd_hop = '0;
            rsp_d.port    = '0;
          end
          rsp_d.status = status_q;
          state_d      = blpm_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = blpm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= blpm_pkg::S_IDLE;
      rsp_valid_q  <= 1'b0;
      root_q       <= '0;
      nodes_used_q <= '0;
    end else begin
      state_q      <= state_d;
      rsp_valid_q  <= rsp_valid_d;
      root_q       <= root_d;
      nodes_used_q <= nodes_used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    cur_mem_q   <= cur_mem_d;
    cur_root_q  <= cur_root_d;
    cur_idx_q   <= cur_idx_d;
    addr_q      <= addr_d;
    len_q       <= len_d;
    level_q     <= level_d;
    op_q        <= op_d;
    hop_q       <= hop_d;
    port_q      <= port_d;
    found_q     <= found_d;
    best_hop_q  <= best_hop_d;
    best_port_q <= best_port_d;
    status_q    <= status_d;
    rsp_q       <= rsp_d;
  end

  a_accept_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> state_q == blpm_pkg::S_WALK)
    else $error("request accepted without starting a walk");

  a_nodes_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nodes_used_q <= LW'(MAX_NODES))
    else $error("node count beyond store size");

  a_write_only_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == blpm_pkg::S_ALLOC)
    else $error("node ram written outside allocation");

  a_rsp_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == blpm_pkg::S_FINISH)
    else $error("response raised without finishing a request");

  a_full_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == blpm_pkg::S_WALK && state_d == blpm_pkg::S_FINISH
      && status_d == blpm_pkg::ST_FULL |=> $stable(nodes_used_q))
    else $error("refused insert changed the node count");

endmodule

`default_nettype wire

FILE: hdl/blpm_ram.sv
// ----------------------------------------------------------------------------
// blpm_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module blpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/blpm_step.sv
// ----------------------------------------------------------------------------
// blpm_step
// Trie step unit: picks the child for the current address bit, checks the
// walk limit and builds the updated node for a link or route write.
// ----------------------------------------------------------------------------
`default_nettype none

module blpm_step #(
  parameter int MAX_NODES    = 4096,
  parameter int ADDRESS_BITS = 32,
  localparam int LW     = $clog2(MAX_NODES + 1),
  localparam int LVW    = $clog2(ADDRESS_BITS + 1),
  localparam int NODE_W = 2 * LW + blpm_pkg::HOP_W + blpm_pkg::PORT_W + 1
) (
  input  wire logic [NODE_W-1:0]           node_i,
  input  wire logic                        bit_i,
  input  wire logic [LVW-1:0]              level_i,
  input  wire logic [LVW-1:0]              limit_i,
  input  wire logic [LW-1:0]               new_link_i,
  input  wire logic [blpm_pkg::HOP_W-1:0]  hop_i,
  input  wire logic [blpm_pkg::PORT_W-1:0] port_i,
  output blpm_pkg::step_t                  step_o,
  output logic      [LW-1:0]               link_o,
  output logic      [NODE_W-1:0]           linked_o,
  output logic      [NODE_W-1:0]           routed_o
);

  typedef struct packed {
    logic [LW-1:0]               child1;
    logic [LW-1:0]               child0;
    logic [blpm_pkg::HOP_W-1:0]  hop;
    logic [blpm_pkg::PORT_W-1:0] port;
    logic                        route;
  } node_t;

  node_t node;
  node_t linked;
  node_t routed;

  assign node   = node_t'(node_i);
  assign link_o = bit_i ? node.child1 : node.child0;

  assign step_o.more     = (level_i < limit_i);
  assign step_o.has_link = (link_o != '0);

  always_comb begin
    linked = node;
    if (bit_i) begin
      linked.child1 = new_link_i;
    end else begin
      linked.child0 = new_link_i;
    end
    routed       = node;
    routed.route = 1'b1;
    routed.hop   = hop_i;
    routed.port  = port_i;
  end

  assign linked_o = linked;
  assign routed_o = routed;

endmodule

`default_nettype wire
